>>> src/wcp_pkg.sv
// Shared types, codes and helpers for the WAV chunk parser.
`default_nettype none

package wcp_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0] PH_RIFF     = 4'd0;
    localparam logic [3:0] PH_RSIZE    = 4'd1;
    localparam logic [3:0] PH_WAVE     = 4'd2;
    localparam logic [3:0] PH_ID       = 4'd3;
    localparam logic [3:0] PH_FMTSIZE  = 4'd4;
    localparam logic [3:0] PH_DATASIZE = 4'd5;
    localparam logic [3:0] PH_SKIPSIZE = 4'd6;
    localparam logic [3:0] PH_FMT      = 4'd7;
    localparam logic [3:0] PH_SKIP     = 4'd8;
    localparam logic [3:0] PH_DATA     = 4'd9;
    localparam logic [3:0] PH_IDLE     = 4'd10;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] FMT_BODY = 32'd16;
    localparam logic [15:0] PCM_TAG  = 16'd1;
    localparam logic [3:0]  FMT_LAST = 4'd15;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NOT_RIFF  = 3'd0;
    localparam logic [2:0] ERR_NOT_WAVE  = 3'd1;
    localparam logic [2:0] ERR_NO_FMT    = 3'd2;
    localparam logic [2:0] ERR_NOT_PCM   = 3'd3;
    localparam logic [2:0] ERR_NO_DATA   = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  sample_byte;
        logic        last_data;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [15:0] bits_per_sample;
        logic [31:0] data_length;
        logic [2:0]  error_code;
    } t_result;

    typedef struct packed {
        t_result    first;
        logic       has_error;
        logic [2:0] error_code;
    } t_entry;

    function automatic t_result error_result(input logic [2:0] code);
        t_result r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/wav_chunk_parser.sv
// Top level: WAV header parser with audio data pass-through.
// Data path: a byte accepted from the input is written into the queue, then moved
// into the registered output by the back end.
// Throughput: one byte per cycle while o_stall is low; a final byte that causes two
// results is stored as one queue entry, and the back end emits the second after it.
// Reset: synchronous active-low clears the parse state, queue and output valid.
`default_nettype none

module wav_chunk_parser #(
    parameter int QUEUE_DEPTH = wcp_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_file_byte,
    input  wire logic        i_end_of_file,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_sample_byte,
    output logic             o_last_data,
    output logic [15:0]      o_channel_count,
    output logic [31:0]      o_rate_hz,
    output logic [15:0]      o_bits_per_sample,
    output logic [31:0]      o_data_length,
    output logic [2:0]       o_error_code
);
    import wcp_pkg::*;

    logic    push;
    t_entry  entry;
    logic    full;
    logic    empty;
    t_entry  head;
    logic    pop;
    t_result result;

    wcp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_file_byte   (i_file_byte),
        .i_end_of_file (i_end_of_file),
        .i_full        (full),
        .o_push        (push),
        .o_entry       (entry)
    );

    wcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    wcp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head),
        .o_pop    (pop),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (result)
    );

    assign o_stall           = full;
    assign o_kind            = result.kind;
    assign o_sample_byte     = result.sample_byte;
    assign o_last_data       = result.last_data;
    assign o_channel_count   = result.channel_count;
    assign o_rate_hz         = result.rate_hz;
    assign o_bits_per_sample = result.bits_per_sample;
    assign o_data_length     = result.data_length;
    assign o_error_code      = result.error_code;

endmodule

`default_nettype wire

>>> src/wcp_front.sv
// Front end: accepts file bytes, walks the RIFF chunks, builds queue entries.
`default_nettype none

module wcp_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_file_byte,
    input  wire logic            i_end_of_file,
    input  wire logic            i_full,
    output logic                 o_push,
    output wcp_pkg::t_entry      o_entry
);
    import wcp_pkg::*;

    logic [3:0]  r_phase,   n_phase;
    logic [3:0]  r_pos,     n_pos;
    logic [31:0] r_shift,   n_shift;
    logic [31:0] r_remain,  n_remain;
    logic [15:0] r_fmt_tag, n_fmt_tag;
    logic [15:0] r_chan,    n_chan;
    logic [31:0] r_rate,    n_rate;
    logic [15:0] r_depth,   n_depth;
    logic        r_fmt_found, n_fmt_found;

    logic        accept;
    logic [31:0] word;
    logic [31:0] remain_dec;
    t_result     res;
    logic        res_valid;
    logic        eof_err;
    logic [2:0]  eof_code;

    assign accept     = i_valid && !i_full;
    assign remain_dec = r_remain - 32'd1;

    always_comb begin
        word = r_shift;
        unique case (r_pos[1:0])
            2'd0: word[7:0]   = i_file_byte;
            2'd1: word[15:8]  = i_file_byte;
            2'd2: word[23:16] = i_file_byte;
            2'd3: word[31:24] = i_file_byte;
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_shift     = r_shift;
        n_remain    = r_remain;
        n_fmt_tag   = r_fmt_tag;
        n_chan      = r_chan;
        n_rate      = r_rate;
        n_depth     = r_depth;
        n_fmt_found = r_fmt_found;
        res         = '0;
        res_valid   = 1'b0;
        eof_err     = 1'b0;
        eof_code    = ERR_NO_DATA;
        if (accept) begin
            unique case (r_phase)
                PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID,
                PH_FMTSIZE, PH_DATASIZE, PH_SKIPSIZE: begin
                    if (r_pos[1:0] != 2'd3) begin
                        n_shift = word;
                        n_pos   = {2'b00, r_pos[1:0] + 2'd1};
                    end else begin
                        n_pos   = '0;
                        n_shift = '0;
                        if (r_phase == PH_RIFF) begin
                            if (word != TAG_RIFF) begin
                                res       = error_result(ERR_NOT_RIFF);
                                res_valid = 1'b1;
                                n_phase   = PH_IDLE;
                            end else begin
                                n_phase = PH_RSIZE;
                            end
                        end else if (r_phase == PH_RSIZE) begin
                            n_phase = PH_WAVE;
                        end else if (r_phase == PH_WAVE) begin
                            if (word != TAG_WAVE) begin
                                res       = error_result(ERR_NOT_WAVE);
                                res_valid = 1'b1;
                                n_phase   = PH_IDLE;
                            end else begin
                                n_phase = PH_ID;
                            end
                        end else if (r_phase == PH_ID) begin
                            if (word == TAG_FMT) begin
                                n_phase = PH_FMTSIZE;
                            end else if (word == TAG_DATA) begin
                                n_phase = PH_DATASIZE;
                            end else begin
                                n_phase = PH_SKIPSIZE;
                            end
                        end else if (r_phase == PH_FMTSIZE) begin
                            n_remain  = (word > FMT_BODY) ? word - FMT_BODY : '0;
                            n_fmt_tag = '0;
                            n_chan    = '0;
                            n_rate    = '0;
                            n_depth   = '0;
                            n_phase   = PH_FMT;
                        end else if (r_phase == PH_SKIPSIZE) begin
                            n_remain = word;
                            n_phase  = (word != '0) ? PH_SKIP : PH_ID;
                        end else begin
                            if (!r_fmt_found) begin
                                res       = error_result(ERR_NO_FMT);
                                res_valid = 1'b1;
                                n_phase   = PH_IDLE;
                            end else if (r_fmt_tag != PCM_TAG) begin
                                res       = error_result(ERR_NOT_PCM);
                                res_valid = 1'b1;
                                n_phase   = PH_IDLE;
                            end else begin
                                res.kind            = KIND_HEADER;
                                res.channel_count   = r_chan;
                                res.rate_hz         = r_rate;
                                res.bits_per_sample = r_depth;
                                res.data_length     = word;
                                res_valid           = 1'b1;
                                n_remain            = word;
                                n_phase             = (word != '0) ? PH_DATA : PH_IDLE;
                            end
                        end
                    end
                end
                PH_FMT: begin
                    unique case (r_pos)
                        4'd0:  n_fmt_tag[7:0]  = i_file_byte;
                        4'd1:  n_fmt_tag[15:8] = i_file_byte;
                        4'd2:  n_chan[7:0]     = i_file_byte;
                        4'd3:  n_chan[15:8]    = i_file_byte;
                        4'd4:  n_rate[7:0]     = i_file_byte;
                        4'd5:  n_rate[15:8]    = i_file_byte;
                        4'd6:  n_rate[23:16]   = i_file_byte;
                        4'd7:  n_rate[31:24]   = i_file_byte;
                        4'd14: n_depth[7:0]    = i_file_byte;
                        4'd15: n_depth[15:8]   = i_file_byte;
                        default: ;
                    endcase
                    if (r_pos != FMT_LAST) begin
                        n_pos = r_pos + 4'd1;
                    end else begin
                        n_pos       = '0;
                        n_fmt_found = 1'b1;
                        n_phase     = (r_remain != '0) ? PH_SKIP : PH_ID;
                    end
                end
                PH_SKIP: begin
                    n_remain = remain_dec;
                    if (remain_dec == '0) begin
                        n_phase = PH_ID;
                    end
                end
                PH_DATA: begin
                    n_remain        = remain_dec;
                    res.kind        = KIND_DATA;
                    res.sample_byte = i_file_byte;
                    res.last_data   = (remain_dec == '0);
                    res_valid       = 1'b1;
                    if (remain_dec == '0) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: ;
            endcase

            if (i_end_of_file) begin
                if (n_phase != PH_IDLE && n_phase <= PH_DATA) begin
                    eof_err = 1'b1;
                    priority if (n_phase == PH_RIFF) begin
                        eof_code = ERR_NOT_RIFF;
                    end else if (n_phase == PH_RSIZE || n_phase == PH_WAVE) begin
                        eof_code = ERR_NOT_WAVE;
                    end else if (n_phase == PH_DATA) begin
                        eof_code = ERR_TRUNCATED;
                    end else begin
                        eof_code = ERR_NO_DATA;
                    end
                end
                n_phase     = PH_RIFF;
                n_pos       = '0;
                n_shift     = '0;
                n_remain    = '0;
                n_fmt_tag   = '0;
                n_chan      = '0;
                n_rate      = '0;
                n_depth     = '0;
                n_fmt_found = 1'b0;
            end
        end
    end

    always_comb begin
        o_entry = '0;
        if (res_valid) begin
            o_entry.first      = res;
            o_entry.has_error  = eof_err;
            o_entry.error_code = eof_code;
        end else begin
            o_entry.first = error_result(eof_code);
        end
    end

    assign o_push = res_valid || eof_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RIFF;
            r_pos       <= '0;
            r_shift     <= '0;
            r_remain    <= '0;
            r_fmt_tag   <= '0;
            r_chan      <= '0;
            r_rate      <= '0;
            r_depth     <= '0;
            r_fmt_found <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_shift     <= n_shift;
            r_remain    <= n_remain;
            r_fmt_tag   <= n_fmt_tag;
            r_chan      <= n_chan;
            r_rate      <= n_rate;
            r_depth     <= n_depth;
            r_fmt_found <= n_fmt_found;
        end
    end

`ifndef SYNTHESIS
    a_data_needs_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_fmt_found && r_remain != '0))
        else $error("data phase without fmt or with nothing left");
    a_eof_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_file) |=> (r_phase == PH_RIFF && !r_fmt_found))
        else $error("parser state not reset after end of file");
`endif

endmodule

`default_nettype wire

>>> src/wcp_queue.sv
// Short register queue between parser front end and output back end.
`default_nettype none

module wcp_queue #(
    parameter int DEPTH = wcp_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire wcp_pkg::t_entry i_entry,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output wcp_pkg::t_entry      o_head
);
    import wcp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && o_empty))
        else $error("queue push when full or pop when empty");
`endif

endmodule

`default_nettype wire

>>> src/wcp_back.sv
// Back end: drains queue entries into the registered result port.
`default_nettype none

module wcp_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_empty,
    input  wire wcp_pkg::t_entry i_head,
    output logic                 o_pop,
    input  wire logic            i_stall,
    output logic                 o_valid,
    output wcp_pkg::t_result     o_result
);
    import wcp_pkg::*;

    logic       r_valid, n_valid;
    logic       r_pend,  n_pend;
    logic [2:0] r_code,  n_code;
    t_result    r_out,   n_out;
    logic       take;

    assign take = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        n_pend  = r_pend;
        n_code  = r_code;
        n_out   = r_out;
        o_pop   = 1'b0;
        if (take) begin
            if (r_pend) begin
                n_out   = error_result(r_code);
                n_valid = 1'b1;
                n_pend  = 1'b0;
            end else if (!i_empty) begin
                o_pop   = 1'b1;
                n_out   = i_head.first;
                n_pend  = i_head.has_error;
                n_code  = i_head.error_code;
                n_valid = 1'b1;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_code <= n_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_pend_behind_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_valid)
        else $error("pending error without a result in the output register");
`endif

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench for wav_chunk_parser: directed and random WAV byte streams checked against a behavioral parser.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wcp_pkg::*;

    localparam int ITEM_TARGET  = 1950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int TAIL_ITEMS   = 150;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } t_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_file_byte = '0;
    logic        i_end_of_file = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_sample_byte;
    logic        o_last_data;
    logic [15:0] o_channel_count;
    logic [31:0] o_rate_hz;
    logic [15:0] o_bits_per_sample;
    logic [31:0] o_data_length;
    logic [2:0]  o_error_code;

    wav_chunk_parser u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_file_byte       (i_file_byte),
        .i_end_of_file     (i_end_of_file),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_kind            (o_kind),
        .o_sample_byte     (o_sample_byte),
        .o_last_data       (o_last_data),
        .o_channel_count   (o_channel_count),
        .o_rate_hz         (o_rate_hz),
        .o_bits_per_sample (o_bits_per_sample),
        .o_data_length     (o_data_length),
        .o_error_code      (o_error_code)
    );

    t_request   pending_requests[$];
    t_result    expected_results[$];
    logic [7:0] file_bytes[$];

    logic [3:0]  parse_phase;
    logic [4:0]  field_idx;
    logic [31:0] tag_shift;
    logic [31:0] left_bytes;
    logic [15:0] fmt_code;
    logic [15:0] chan_acc;
    logic [31:0] rate_acc;
    logic [15:0] depth_acc;
    logic        fmt_seen;

    int   failures = 0;
    int   files_queued = 0;
    int   bytes_sent = 0;
    int   headers_seen = 0;
    int   data_seen = 0;
    int   errors_seen = 0;
    logic [5:0] codes_seen = '0;
    int   cycle_count = 0;
    int   send_gap = 0;
    int   stall_left = 0;
    int   window_left = 60;
    logic idle_on = 1'b1;
    logic calm_tail = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic reset_parse();
        parse_phase = PH_RIFF;
        field_idx   = '0;
        tag_shift   = '0;
        left_bytes  = '0;
        fmt_code    = '0;
        chan_acc    = '0;
        rate_acc    = '0;
        depth_acc   = '0;
        fmt_seen    = 1'b0;
    endtask

    task automatic push_error(input logic [2:0] code);
        t_result r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        expected_results.push_back(r);
        parse_phase = PH_IDLE;
    endtask

    task automatic parse_file_byte(input logic [7:0] fb, input logic eof);
        logic [31:0] word;
        logic [1:0]  slot;
        logic [3:0]  body_idx;
        logic [2:0]  code;
        t_result     r;
        case (parse_phase)
            PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_FMTSIZE, PH_DATASIZE, PH_SKIPSIZE: begin
                slot = field_idx[1:0];
                tag_shift = tag_shift | (32'(fb) << (8 * slot));
                if (slot != 2'd3) begin
                    field_idx = {3'b000, slot} + 5'd1;
                end else begin
                    field_idx = '0;
                    word      = tag_shift;
                    tag_shift = '0;
                    case (parse_phase)
                        PH_RIFF: begin
                            if (word != TAG_RIFF) push_error(ERR_NOT_RIFF);
                            else parse_phase = PH_RSIZE;
                        end
                        PH_RSIZE: parse_phase = PH_WAVE;
                        PH_WAVE: begin
                            if (word != TAG_WAVE) push_error(ERR_NOT_WAVE);
                            else parse_phase = PH_ID;
                        end
                        PH_ID: begin
                            if (word == TAG_FMT) parse_phase = PH_FMTSIZE;
                            else if (word == TAG_DATA) parse_phase = PH_DATASIZE;
                            else parse_phase = PH_SKIPSIZE;
                        end
                        PH_FMTSIZE: begin
                            left_bytes  = (word > FMT_BODY) ? word - FMT_BODY : '0;
                            fmt_code    = '0;
                            chan_acc    = '0;
                            rate_acc    = '0;
                            depth_acc   = '0;
                            parse_phase = PH_FMT;
                        end
                        PH_SKIPSIZE: begin
                            left_bytes  = word;
                            parse_phase = (word != '0) ? PH_SKIP : PH_ID;
                        end
                        PH_DATASIZE: begin
                            if (!fmt_seen) begin
                                push_error(ERR_NO_FMT);
                            end else if (fmt_code != PCM_TAG) begin
                                push_error(ERR_NOT_PCM);
                            end else begin
                                r                 = '0;
                                r.kind            = KIND_HEADER;
                                r.channel_count   = chan_acc;
                                r.rate_hz         = rate_acc;
                                r.bits_per_sample = depth_acc;
                                r.data_length     = word;
                                expected_results.push_back(r);
                                left_bytes  = word;
                                parse_phase = (word != '0) ? PH_DATA : PH_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            PH_FMT: begin
                body_idx = field_idx[3:0];
                if (body_idx < 4'd2)
                    fmt_code = fmt_code | 16'(16'(fb) << (8 * body_idx));
                else if (body_idx < 4'd4)
                    chan_acc = chan_acc | 16'(16'(fb) << (8 * (body_idx - 4'd2)));
                else if (body_idx < 4'd8)
                    rate_acc = rate_acc | (32'(fb) << (8 * (body_idx - 4'd4)));
                else if (body_idx >= 4'd14)
                    depth_acc = depth_acc | 16'(16'(fb) << (8 * (body_idx - 4'd14)));
                if (body_idx != FMT_LAST) begin
                    field_idx = {1'b0, body_idx} + 5'd1;
                end else begin
                    field_idx   = '0;
                    fmt_seen    = 1'b1;
                    parse_phase = (left_bytes != '0) ? PH_SKIP : PH_ID;
                end
            end
            PH_SKIP: begin
                left_bytes = left_bytes - 32'd1;
                if (left_bytes == '0) parse_phase = PH_ID;
            end
            PH_DATA: begin
                left_bytes    = left_bytes - 32'd1;
                r             = '0;
                r.kind        = KIND_DATA;
                r.sample_byte = fb;
                r.last_data   = (left_bytes == '0);
                expected_results.push_back(r);
                if (left_bytes == '0) parse_phase = PH_IDLE;
            end
            default: ;
        endcase
        if (eof) begin
            if (parse_phase != PH_IDLE && parse_phase <= PH_DATA) begin
                if (parse_phase == PH_RIFF) code = ERR_NOT_RIFF;
                else if (parse_phase == PH_RSIZE || parse_phase == PH_WAVE) code = ERR_NOT_WAVE;
                else if (parse_phase == PH_DATA) code = ERR_TRUNCATED;
                else code = ERR_NO_DATA;
                push_error(code);
            end
            reset_parse();
        end
    endtask

    task automatic put_le32(input logic [31:0] v);
        for (int k = 0; k < 4; k++) file_bytes.push_back(v[8*k +: 8]);
    endtask

    task automatic put_le16(input logic [15:0] v);
        file_bytes.push_back(v[7:0]);
        file_bytes.push_back(v[15:8]);
    endtask

    task automatic put_random_bytes(input int count);
        repeat (count) file_bytes.push_back(8'($urandom));
    endtask

    task automatic queue_file(input bit may_cut);
        t_request req;
        int       keep;
        keep = file_bytes.size();
        if (may_cut && keep > 1 && $urandom_range(0, 9) == 0)
            keep = $urandom_range(1, keep - 1);
        for (int k = 0; k < keep; k++) begin
            req.data = file_bytes[k];
            req.eof  = (k == keep - 1);
            pending_requests.push_back(req);
        end
        files_queued++;
    endtask

    task automatic put_other_chunk();
        int sz;
        sz = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) put_le32(TAG_DATA ^ (32'd1 << $urandom_range(0, 31)));
        else put_le32($urandom);
        put_le32(sz);
        put_random_bytes(sz);
    endtask

    task automatic put_fmt_chunk();
        int          pick;
        logic [31:0] fsz;
        pick = $urandom_range(0, 9);
        if (pick < 6) fsz = FMT_BODY;
        else if (pick < 8) fsz = $urandom_range(0, 15);
        else fsz = $urandom_range(17, 22);
        put_le32(TAG_FMT);
        put_le32(fsz);
        put_le16($urandom_range(0, 7) != 0 ? PCM_TAG : 16'($urandom));
        pick = $urandom_range(0, 9);
        put_le16(pick == 0 ? 16'hFFFF : pick == 1 ? 16'h0000 : 16'($urandom_range(1, 8)));
        pick = $urandom_range(0, 9);
        put_le32(pick == 0 ? 32'hFFFF_FFFF : pick == 1 ? 32'h0 : $urandom);
        put_random_bytes(6);
        pick = $urandom_range(0, 9);
        put_le16(pick == 0 ? 16'hFFFF : pick == 1 ? 16'h0000 : 16'($urandom));
        if (fsz > FMT_BODY) put_random_bytes(fsz - FMT_BODY);
    endtask

    task automatic put_data_chunk();
        int          pick;
        int          body_len;
        logic [31:0] data_sz;
        pick = $urandom_range(0, 9);
        if (pick < 7) data_sz = $urandom_range(1, 24);
        else if (pick < 8) data_sz = '0;
        else if (pick < 9) data_sz = 32'hFFFF_FFFF;
        else data_sz = $urandom;
        put_le32(TAG_DATA);
        put_le32(data_sz);
        body_len = (data_sz > 32'd24) ? $urandom_range(0, 24) : int'(data_sz);
        put_random_bytes(body_len);
        if (body_len == int'(data_sz)) put_random_bytes($urandom_range(0, 3));
    endtask

    task automatic build_random_file();
        int pick;
        file_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            put_random_bytes($urandom_range(1, 12));
        end else begin
            put_le32(pick < 9 ? TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)) : TAG_RIFF);
            put_le32($urandom);
            put_le32(pick < 13 ? TAG_WAVE ^ (32'd1 << $urandom_range(0, 31)) : TAG_WAVE);
            repeat ($urandom_range(0, 2)) put_other_chunk();
            if ($urandom_range(0, 19) == 0) begin
                put_le32($urandom);
                put_le32($urandom | 32'h100);
                put_random_bytes($urandom_range(0, 6));
            end else begin
                if ($urandom_range(0, 9) != 0) put_fmt_chunk();
                if ($urandom_range(0, 4) == 0) put_other_chunk();
                if ($urandom_range(0, 5) == 0) put_fmt_chunk();
                if ($urandom_range(0, 9) != 0) put_data_chunk();
            end
        end
        queue_file(1'b1);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin : driver
        t_request req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                parse_file_byte(i_file_byte, i_end_of_file);
                bytes_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    req = pending_requests[0];
                    pending_requests.delete(0);
                    i_valid       <= 1'b1;
                    i_file_byte   <= req.data;
                    i_end_of_file <= req.eof;
                    if (idle_on && !calm_tail && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 19);
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (pending_requests.size() < TAIL_ITEMS) calm_tail <= 1'b1;
            if (window_left == 0) begin
                idle_on     <= !idle_on;
                window_left = $urandom_range(40, 160);
            end else begin
                window_left--;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got.kind            = o_kind;
                got.sample_byte     = o_sample_byte;
                got.last_data       = o_last_data;
                got.channel_count   = o_channel_count;
                got.rate_hz         = o_rate_hz;
                got.bits_per_sample = o_bits_per_sample;
                got.data_length     = o_data_length;
                got.error_code      = o_error_code;
                if (expected_results.size() == 0) begin
                    $display("%0t: extra result, expected none, actual kind %0d byte %0h code %0d",
                             $time, got.kind, got.sample_byte, got.error_code);
                    failures++;
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    check_field("kind", 32'(want.kind), 32'(got.kind));
                    check_field("sample_byte", 32'(want.sample_byte), 32'(got.sample_byte));
                    check_field("last_data", 32'(want.last_data), 32'(got.last_data));
                    check_field("channel_count", 32'(want.channel_count),
                                32'(got.channel_count));
                    check_field("rate_hz", want.rate_hz, got.rate_hz);
                    check_field("bits_per_sample", 32'(want.bits_per_sample),
                                32'(got.bits_per_sample));
                    check_field("data_length", want.data_length, got.data_length);
                    check_field("error_code", 32'(want.error_code), 32'(got.error_code));
                end
                if (got.kind == KIND_HEADER) headers_seen++;
                else if (got.kind == KIND_DATA) data_seen++;
                else begin
                    errors_seen++;
                    if (got.error_code <= ERR_TRUNCATED) codes_seen[got.error_code] = 1'b1;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (idle_on && !calm_tail && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 18);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        reset_parse();

        file_bytes.delete();
        file_bytes.push_back(8'h00);
        queue_file(1'b0);

        file_bytes.delete();
        put_le32(TAG_RIFF ^ 32'h1000_0000);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h00);
        queue_file(1'b0);

        file_bytes.delete();
        put_le32(TAG_RIFF);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h7F);
        queue_file(1'b0);

        file_bytes.delete();
        put_le32(TAG_RIFF);
        put_le32(32'hFFFF_FFFF);
        put_le32(TAG_WAVE ^ 32'h0100_0000);
        queue_file(1'b0);

        while (pending_requests.size() < ITEM_TARGET) build_random_file();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_results.size() > 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
            failures++;
        end
        $display("Parsed %0d bytes in %0d files: %0d header reports, %0d data bytes, %0d errors",
                 bytes_sent, files_queued, headers_seen, data_seen, errors_seen);
        $display("Error codes observed (bit per code, code 0 rightmost): %b", codes_seen);
        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
src/wcp_pkg.sv
src/wcp_front.sv
src/wcp_queue.sv
src/wcp_back.sv
src/wav_chunk_parser.sv
dv/tb.sv
